// File: rtl/assert_macros.svh
// Assertion macros for the RTL top level, which carries the concurrent checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication check, disabled while reset is asserted.
`define SFD_ASSERT(label, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("slip_frame_decoder assertion failed");

// Check that an expression is never true outside reset.
`define SFD_NEVER(label, expr) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
    else $error("slip_frame_decoder forbidden condition seen");

`endif

// File: rtl/sfd_pkg.sv
// Package with SLIP codes and controller/datapath interface types.
package sfd_pkg;

  localparam int unsigned BYTE_W = 8;
  localparam int unsigned LEN_W  = 7;

  localparam logic [BYTE_W-1:0] CODE_END     = 8'hC0;
  localparam logic [BYTE_W-1:0] CODE_ESC     = 8'hDB;
  localparam logic [BYTE_W-1:0] CODE_ESC_END = 8'hDC;
  localparam logic [BYTE_W-1:0] CODE_ESC_ESC = 8'hDD;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic accept;      // input transfer happens this cycle
    logic issue_read;  // read the next packet byte from the store
    logic load_out;    // move the read data into the output register
  } sfd_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic frame_end;   // current input byte closes a non-empty frame
    logic rd_last;     // read pointer sits on the final packet byte
    logic out_free;    // output register is empty after this edge
  } sfd_sts_t;

endpackage

// File: rtl/sfd_ctrl.sv
// Controller state machine: accepts input bytes and sequences the packet drain.
module sfd_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  sfd_pkg::sfd_sts_t sts,
  output sfd_pkg::sfd_cmd_t cmd
);
  import sfd_pkg::*;

  typedef enum logic {
    ST_IDLE,
    ST_DRAIN
  } state_t;

  state_t state_r;
  state_t state_nxt;
  logic   load_pend_r;
  logic   load_pend_nxt;

  assign in_ready       = (state_r == ST_IDLE);
  assign cmd.accept     = in_valid && (state_r == ST_IDLE);
  assign cmd.issue_read = (state_r == ST_DRAIN) && !load_pend_r && sts.out_free;
  assign cmd.load_out   = load_pend_r;

  always_comb begin
    state_nxt     = state_r;
    load_pend_nxt = cmd.issue_read;
    unique case (state_r)
      ST_IDLE: begin
        if (cmd.accept && sts.frame_end) begin
          state_nxt = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (cmd.issue_read && sts.rd_last) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      load_pend_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      load_pend_r <= load_pend_nxt;
    end
  end

endmodule

// File: rtl/sfd_datapath.sv
// Datapath: escape decoding, packet store, read pointer and output register.
module sfd_datapath #(
  parameter int unsigned MAX_PACKET = 64
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic [sfd_pkg::BYTE_W-1:0] in_rx_byte,
  input  sfd_pkg::sfd_cmd_t          cmd,
  output sfd_pkg::sfd_sts_t          sts,
  input  logic                       out_ready,
  output logic                       out_valid,
  output logic [sfd_pkg::BYTE_W-1:0] out_packet_byte,
  output logic                       out_last_byte,
  output logic [sfd_pkg::LEN_W-1:0]  out_packet_length
);
  import sfd_pkg::*;

  localparam int unsigned AW = (MAX_PACKET > 1) ? $clog2(MAX_PACKET) : 1;

  logic [BYTE_W-1:0] store_mem [MAX_PACKET];

  logic              escape_pending_r;
  logic              escape_pending_nxt;
  logic [LEN_W-1:0]  fill_count_r;
  logic [LEN_W-1:0]  fill_count_nxt;
  logic [LEN_W-1:0]  len_r;
  logic [AW-1:0]     rd_ptr_r;
  logic [BYTE_W-1:0] rd_data_r;
  logic              rd_last_r;
  logic              out_valid_r;
  logic [BYTE_W-1:0] out_byte_r;
  logic              out_last_r;
  logic [LEN_W-1:0]  out_len_r;

  logic              store_en;
  logic [BYTE_W-1:0] store_byte;
  logic              has_room;
  logic              frame_end;

  assign has_room = (fill_count_r < LEN_W'(MAX_PACKET));

  always_comb begin
    store_en           = 1'b0;
    store_byte         = in_rx_byte;
    frame_end          = 1'b0;
    escape_pending_nxt = escape_pending_r;
    priority if (escape_pending_r) begin
      escape_pending_nxt = 1'b0;
      if (in_rx_byte == CODE_ESC_END) begin
        store_en   = 1'b1;
        store_byte = CODE_END;
      end else if (in_rx_byte == CODE_ESC_ESC) begin
        store_en   = 1'b1;
        store_byte = CODE_ESC;
      end
    end else if (in_rx_byte == CODE_ESC) begin
      escape_pending_nxt = 1'b1;
    end else if (in_rx_byte != CODE_END) begin
      store_en = 1'b1;
    end else begin
      frame_end = (fill_count_r != '0);
    end
  end

  always_comb begin
    fill_count_nxt = fill_count_r;
    if (store_en) begin
      fill_count_nxt = has_room ? (fill_count_r + LEN_W'(1)) : '0;
    end else if (frame_end) begin
      fill_count_nxt = '0;
    end
  end

  assign sts.frame_end = frame_end;
  assign sts.rd_last   = (({{(LEN_W-AW){1'b0}}, rd_ptr_r} + LEN_W'(1)) == len_r);
  assign sts.out_free  = !out_valid_r || out_ready;

  // Packet store: written while bytes arrive, read one byte per issue.
  always_ff @(posedge clk) begin
    if (cmd.accept && store_en && has_room) begin
      store_mem[fill_count_r[AW-1:0]] <= store_byte;
    end
    if (cmd.issue_read) begin
      rd_data_r <= store_mem[rd_ptr_r];
      rd_last_r <= sts.rd_last;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      escape_pending_r <= 1'b0;
      fill_count_r     <= '0;
      rd_ptr_r         <= '0;
      out_valid_r      <= 1'b0;
    end else begin
      if (cmd.accept) begin
        escape_pending_r <= escape_pending_nxt;
        fill_count_r     <= fill_count_nxt;
        if (frame_end) begin
          rd_ptr_r <= '0;
        end
      end
      if (cmd.issue_read) begin
        rd_ptr_r <= rd_ptr_r + AW'(1);
      end
      if (cmd.load_out) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept && frame_end) begin
      len_r <= fill_count_r;
    end
    if (cmd.load_out) begin
      out_byte_r <= rd_data_r;
      out_last_r <= rd_last_r;
      out_len_r  <= len_r;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_packet_byte   = out_byte_r;
  assign out_last_byte     = out_last_r;
  assign out_packet_length = out_len_r;

endmodule

// File: rtl/slip_frame_decoder.sv
// Top level of the SLIP receive deframer: controller plus datapath.
//
// Input channel: in_valid/in_ready with in_rx_byte, one raw serial byte per
// transfer. END closes a frame, ESC followed by ESC_END or ESC_ESC yields a
// literal END or ESC byte, and ESC followed by anything else drops that byte.
// While collecting a frame the block takes one byte per cycle.
// Result channel: out_valid/out_ready with out_packet_byte, out_last_byte
// and out_packet_length. A completed packet of n bytes is read out of the
// packet store in order; out_last_byte marks the final byte and every
// transfer repeats the packet length.
// The first byte of a packet passes the controller state, the read data
// register and the output register after the closing END transfer. The
// store has one read port with registered data, and each read waits for the
// previous byte to land in the output register. in_ready stays low from
// the closing END until the last byte has been read.
// When the receiver stalls, the output register holds its byte and the drain
// pauses; the next input byte is taken while the final byte still waits.
// Reset (rst_n low, synchronous) empties the store, clears the escape flag
// and the output valid flag. Empty frames give nothing; a data byte that
// finds the store full is dropped and empties it.
module slip_frame_decoder #(
  parameter int unsigned MAX_PACKET = 64
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic [sfd_pkg::BYTE_W-1:0] in_rx_byte,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic [sfd_pkg::BYTE_W-1:0] out_packet_byte,
  output logic                       out_last_byte,
  output logic [sfd_pkg::LEN_W-1:0]  out_packet_length
);
  import sfd_pkg::*;

  `include "assert_macros.svh"

  sfd_cmd_t cmd;
  sfd_sts_t sts;

  // The controller owns the handshake on the input side and the read
  // sequencing; the datapath holds all stored data.
  sfd_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  sfd_datapath #(
    .MAX_PACKET (MAX_PACKET)
  ) u_datapath (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_rx_byte        (in_rx_byte),
    .cmd               (cmd),
    .sts               (sts),
    .out_ready         (out_ready),
    .out_valid         (out_valid),
    .out_packet_byte   (out_packet_byte),
    .out_last_byte     (out_last_byte),
    .out_packet_length (out_packet_length)
  );

  // The store is never read while input bytes may be written into it.
  `SFD_NEVER(a_no_read_while_ready, cmd.issue_read && in_ready)
  // Only one store read is in flight at a time.
  `SFD_ASSERT(a_single_read, cmd.issue_read |=> !cmd.issue_read)
  // A closing END stops the input until the packet has been read.
  `SFD_ASSERT(a_drain_blocks_input, (cmd.accept && sts.frame_end) |=> !in_ready)

endmodule
